>>> rtl/fractal_value_noise_top_assert.svh
// ----------------------------------------------------------------------------
// Fractal value noise assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_TOP_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_TOP_ASSERT_SVH

// Same-cycle implication
`define FVN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fvn_pkg.sv
// ----------------------------------------------------------------------------
// Fractal value noise package
// Hash constants, register codes and reset values, per-octave control bundle.
// ----------------------------------------------------------------------------
package fvn_pkg;

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    CFG_AMPLITUDE   = 2'd0,
    CFG_PERSISTENCE = 2'd1,
    CFG_OCTAVES     = 2'd2,
    CFG_SEED        = 2'd3
  } cfg_idx_e;

  localparam logic [23:0] AMP_RST    = 24'd65536;
  localparam logic [19:0] PERS_RST   = 20'd43691;
  localparam logic [4:0]  OCT_RST    = 5'd6;
  localparam logic [15:0] SEED_RST   = 16'd0;

  // Lattice hash constants
  localparam logic [31:0] H1_C1      = 32'd15731;
  localparam logic [31:0] H1_C2      = 32'd789221;
  localparam logic [31:0] H2_C1      = 32'd60493;
  localparam logic [31:0] H2_C2      = 32'd19990303;
  localparam logic [31:0] H_C3       = 32'd1376312589;
  localparam logic [31:0] H_MASK     = 32'h7fffffff;
  localparam logic [31:0] Y_STRIDE   = 32'd57;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Per-octave control carried down the pipeline
  typedef struct packed {
    logic        mode;
    logic        first;
    logic        last;
    logic        zero;
    logic [15:0] xf;
    logic [15:0] yf;
    logic [31:0] amp;
  } oct_ctl_t;

endpackage

>>> rtl/fractal_value_noise_top.sv
// Path: an input transfer loads the octave sequencer; each octave runs through the
//   ten-stage octave pipeline into the accumulator and then the output register.
// Flow: a new item is accepted when the sequencer is idle or on its last octave; the one
//   pipelined octave unit (sixteen lattice hashes) takes one octave per cycle unless held.
// Reset: rst_ni clears valid bits, sequencer and configuration registers to their defaults at once.
// ----------------------------------------------------------------------------
// Fractal value noise top level
// Octave sequencer feeding a ten-stage octave pipeline and a saturating accumulator.
// ----------------------------------------------------------------------------
module fractal_value_noise_top #(
  parameter int MAX_OCTAVES    = 16,
  parameter int COS_TABLE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // coord_x [31:0], coord_y [63:32]
  input  logic        s_axis_tuser_i,   // operation [0]
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // noise_value [31:0]
  output logic        m_axis_tuser_o    // clipped [0]
);
  import fvn_pkg::*;

  localparam int TBL   = 1 << COS_TABLE_BITS;
  localparam int RW    = $clog2(MAX_OCTAVES + 1);
  localparam int SW    = 38;
  localparam int TW    = 35;
  localparam int ACC_W = TW + $clog2(MAX_OCTAVES + 1);

  typedef logic [16:0] wtbl_t [TBL];

  // Shift-and-subtract quotient, used only while building the weight table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] half_w(int k);
    longint unsigned a;
    longint unsigned term;
    longint          c;
    longint          r;
    a    = (PI_Q30 * longint'(k)) >> COS_TABLE_BITS;
    term = 64'd1 << 30;
    c    = 64'sd1 <<< 30;
    for (int n = 1; n <= 9; n++) begin
      term = (((term * a) >> 30) * a) >> 30;
      term = udiv64(term, longint'((2 * n - 1) * (2 * n)));
      if ((n & 1) != 0) c = c - longint'(term);
      else c = c + longint'(term);
    end
    r = ((64'sd1 <<< 30) - c + (64'sd1 <<< 14)) >>> 15;
    return 17'(r);
  endfunction

  function automatic wtbl_t build_tbl();
    wtbl_t t;
    for (int k = 0; k < TBL; k++) begin
      if (2 * k <= TBL) t[k] = half_w(k);
      else t[k] = 17'(65536 - int'(half_w(TBL - k)));
    end
    return t;
  endfunction

  localparam wtbl_t WTBL = build_tbl();

  // Configuration registers
  logic [23:0] amp_gain_q;
  logic [19:0] pers_gain_q;
  logic [4:0]  oct_cnt_q;
  logic [15:0] seed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_gain_q  <= AMP_RST;
      pers_gain_q <= PERS_RST;
      oct_cnt_q   <= OCT_RST;
      seed_q      <= SEED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AMPLITUDE:   amp_gain_q  <= cfg_data_i;
        CFG_PERSISTENCE: pers_gain_q <= cfg_data_i[19:0];
        CFG_OCTAVES:     oct_cnt_q   <= cfg_data_i[4:0];
        CFG_SEED:        seed_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipeline moves unless the output is held
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready_i;

  // Octave sequencer
  logic          busy_q, first_q, zero_q, mode_q;
  logic [RW-1:0] rem_q;
  logic [47:0]   sx_q, sy_q;
  logic [31:0]   amp_q;
  logic          accept;
  logic [5:0]    cnt_full, cnt_clamp;
  logic [51:0]   amp_prod;
  logic [35:0]   amp_rnd;
  logic [31:0]   amp_next;

  assign s_axis_tready_o = en && (!busy_q || rem_q == RW'(1));
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_full        = {1'b0, oct_cnt_q};
  assign cnt_clamp       = (cnt_full > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES) : cnt_full;
  assign amp_prod        = 52'(amp_q) * 52'(pers_gain_q);
  assign amp_rnd         = 36'((amp_prod + 52'd32768) >> 16);
  assign amp_next        = (amp_rnd[35:32] != 4'd0) ? 32'hffffffff : amp_rnd[31:0];

  // Stage registers
  logic        v_q [1:10];
  oct_ctl_t    ctl_q [1:10];
  logic [31:0] xi1_q, yi1_q;
  logic [31:0] h2_q [16];
  logic [31:0] h3_q [16];
  logic [31:0] hh3_q [16];
  logic [31:0] h4_q [16];
  logic [31:0] t4_q [16];
  logic signed [31:0] nz5_q [16];
  logic signed [SW-1:0] s6_q [4];
  logic [16:0] wx6_q, wy6_q;
  logic signed [SW-1:0] i1_7_q, i2_7_q;
  logic [16:0] wy7_q;
  logic signed [31:0] q30_8_q;
  logic signed [48:0] plo9_q, phi9_q;
  logic signed [TW-1:0] term10_q;

  // Valid bits and control travel together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 10; s++) v_q[s] <= 1'b0;
      busy_q <= 1'b0;
    end else if (en) begin
      v_q[1] <= busy_q;
      for (int s = 2; s <= 10; s++) v_q[s] <= v_q[s-1];
      if (accept) busy_q <= 1'b1;
      else if (busy_q && rem_q == RW'(1)) busy_q <= 1'b0;
    end
  end

  // Sequencer payload and stage 1 issue
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 2; s <= 10; s++) ctl_q[s] <= ctl_q[s-1];
      ctl_q[1].mode  <= mode_q;
      ctl_q[1].first <= first_q;
      ctl_q[1].last  <= (rem_q == RW'(1));
      ctl_q[1].zero  <= zero_q;
      ctl_q[1].xf    <= sx_q[15:0];
      ctl_q[1].yf    <= sy_q[15:0];
      ctl_q[1].amp   <= amp_q;
      xi1_q          <= sx_q[47:16];
      yi1_q          <= sy_q[47:16];
      if (accept) begin
        mode_q  <= s_axis_tuser_i;
        first_q <= 1'b1;
        zero_q  <= (cnt_full == 6'd0);
        rem_q   <= (cnt_full == 6'd0) ? RW'(1) : RW'(cnt_clamp);
        sx_q    <= 48'({{16{s_axis_tdata_i[31]}}, s_axis_tdata_i[31:0]})
                   + {16'd0, seed_q, 16'd0};
        sy_q    <= 48'({{16{s_axis_tdata_i[63]}}, s_axis_tdata_i[63:32]})
                   + {16'd0, seed_q, 16'd0};
        amp_q   <= {8'd0, amp_gain_q};
      end else if (busy_q) begin
        first_q <= 1'b0;
        rem_q   <= rem_q - RW'(1);
        sx_q    <= {sx_q[46:0], 1'b0};
        sy_q    <= {sy_q[46:0], 1'b0};
        amp_q   <= amp_next;
      end
    end
  end

  // Stage 2: lattice indexes and first hash mix
  logic [31:0] n_c [16];
  always_comb begin
    logic [31:0] xa, ya;
    for (int j = 0; j < 16; j++) begin
      xa = xi1_q + 32'(j & 3) - 32'd1;
      ya = yi1_q + 32'(j >> 2) - 32'd1;
      n_c[j] = ctl_q[1].mode ? 32'(xa + 32'(ya * Y_STRIDE)) : xa;
    end
  end

  // Stages 2 to 5: first hash mix, then hash multiplies in stages 3 to 5, one per stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 16; j++) begin
        h2_q[j]  <= n_c[j] ^ {n_c[j][18:0], 13'd0};
        h3_q[j]  <= h2_q[j];
        hh3_q[j] <= 32'(h2_q[j] * h2_q[j]);
        h4_q[j]  <= h3_q[j];
        t4_q[j]  <= 32'(hh3_q[j] * (ctl_q[3].mode ? H2_C1 : H1_C1))
                    + (ctl_q[3].mode ? H2_C2 : H1_C2);
        nz5_q[j] <= $signed(32'h40000000)
                    - $signed((32'(h4_q[j] * t4_q[j]) + H_C3) & H_MASK);
      end
    end
  end

  // Stage 6: smoothing filter and blend weights
  logic signed [SW-1:0] s_c [4];
  always_comb begin
    logic signed [SW-1:0] acc2, acc1;
    int gx, gy, px, py, wsh;
    for (int p = 0; p < 4; p++) begin
      px   = p & 1;
      py   = p >> 1;
      gx   = px + 1;
      gy   = py + 1;
      acc2 = '0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          wsh  = ((dx == 0) ? 1 : 0) + ((dy == 0) ? 1 : 0);
          acc2 = acc2 + (SW'(nz5_q[(gy + dy) * 4 + gx + dx]) <<< wsh);
        end
      end
      acc1 = (SW'(nz5_q[px + 1]) <<< 1) + SW'(nz5_q[px]) + SW'(nz5_q[px + 2]);
      s_c[p] = ctl_q[5].mode ? acc2 : acc1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 4; p++) s6_q[p] <= s_c[p];
      wx6_q <= WTBL[ctl_q[5].xf[15 -: COS_TABLE_BITS]];
      wy6_q <= WTBL[ctl_q[5].yf[15 -: COS_TABLE_BITS]];
    end
  end

  // Stage 7: blend along x
  logic signed [SW+18:0] bx1_c, bx2_c;
  assign bx1_c = (SW'(s6_q[1]) - SW'(s6_q[0])) * $signed({1'b0, wx6_q});
  assign bx2_c = (SW'(s6_q[3]) - SW'(s6_q[2])) * $signed({1'b0, wx6_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      i1_7_q <= s6_q[0] + SW'(bx1_c >>> 16);
      i2_7_q <= s6_q[2] + SW'(bx2_c >>> 16);
      wy7_q  <= wy6_q;
    end
  end

  // Stage 8: blend along y and drop to Q1.30
  logic signed [SW+18:0] by_c;
  logic signed [SW-1:0]  iy_c;
  assign by_c = (i2_7_q - i1_7_q) * $signed({1'b0, wy7_q});
  assign iy_c = i1_7_q + SW'(by_c >>> 16);

  always_ff @(posedge clk_i) begin
    if (en) q30_8_q <= ctl_q[7].mode ? 32'(iy_c >>> 4) : 32'(i1_7_q >>> 2);
  end

  // Stages 9 and 10: amplitude scaling as two partial products, then round
  logic signed [65:0] sc_c;
  assign sc_c = 66'(plo9_q) + (66'(phi9_q) <<< 16) + 66'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo9_q   <= q30_8_q * $signed({1'b0, ctl_q[8].amp[15:0]});
      phi9_q   <= q30_8_q * $signed({1'b0, ctl_q[8].amp[31:16]});
      term10_q <= ctl_q[9].zero ? '0 : TW'(sc_c >>> 30);
    end
  end

  // Accumulate octave terms and saturate the finished sum
  logic signed [ACC_W-1:0] acc_q, sum_c;
  logic [31:0] out_data_q;
  logic        out_clip_q;
  assign sum_c = (ctl_q[10].first ? '0 : acc_q) + ACC_W'(term10_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= v_q[10] && ctl_q[10].last;
  end

  always_ff @(posedge clk_i) begin
    if (en && v_q[10]) begin
      acc_q <= sum_c;
      if (sum_c > ACC_W'(64'sd2147483647)) begin
        out_data_q <= 32'h7fffffff;
        out_clip_q <= 1'b1;
      end else if (sum_c < -ACC_W'(64'sd2147483648)) begin
        out_data_q <= 32'h80000000;
        out_clip_q <= 1'b1;
      end else begin
        out_data_q <= 32'(sum_c);
        out_clip_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_clip_q;

`include "fractal_value_noise_top_assert.svh"

  `FVN_ASSERT_NOW(a_ready_needs_adv, s_axis_tready_o, en, "input ready while pipeline held")
  `FVN_ASSERT_NOW(a_busy_rem, busy_q, rem_q != '0, "sequencer busy with no octave left")
  `FVN_ASSERT_NEXT(a_last_out, en && v_q[10] && ctl_q[10].last, out_vld_q,
                   "last octave did not produce a result")

endmodule
